@@ rtl/cbq_pkg.sv @@
// Shared types, register indexes and tap codes for the cascaded biquad filter.
`timescale 1ns / 1ps

package cbq_pkg;

  // Coefficient and register file widths
  localparam int COEF_W      = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int SECT_CNT_W  = 5;

  // Default build configuration
  localparam int DEF_NUM_SECTIONS   = 16;
  localparam int DEF_SAMPLE_BITS    = 24;
  localparam int DEF_COEF_FRAC_BITS = 28;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_B0       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SECTIONS = 3'd6;

  // Register reset values (b0 = 1.0 in Q3.28)
  localparam logic signed [COEF_W-1:0] B0_RESET = 32'sh1000_0000;

  // Multiply tap codes, one per term of the section equation
  typedef logic [2:0] tap_t;
  localparam tap_t TAP_B0 = 3'd0;
  localparam tap_t TAP_B1 = 3'd1;
  localparam tap_t TAP_B2 = 3'd2;
  localparam tap_t TAP_A1 = 3'd3;
  localparam tap_t TAP_A2 = 3'd4;

  // Shared filter coefficients
  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // latch the accepted sample
    logic rd;     // read section history, clear accumulator
    logic mul;    // multiply one tap
    tap_t tap;    // which tap
    logic round;  // round, saturate, write back history
    logic emit;   // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_busy;  // output register holds a request that is stalled
  } status_t;

endpackage

@@ rtl/cbq_ctrl.sv @@
// Sequencer for the cascaded biquad filter: walks sections and taps.
`timescale 1ns / 1ps

module cbq_ctrl import cbq_pkg::*; #(
  parameter int NUM_SECTIONS = DEF_NUM_SECTIONS,
  parameter int SEC_W        = 4,
  parameter int CNT_W        = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  filter_on,
  input  logic [SECT_CNT_W-1:0] sections_in_use,
  input  status_t               status,
  output cmd_t                  cmd,
  output logic [SEC_W-1:0]      sec_addr
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;
  localparam logic [2:0] ST_ROUND = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]       state, state_next;
  tap_t             tap, tap_next;
  logic [CNT_W-1:0] sec, sec_next;
  logic [CNT_W-1:0] num_sec;
  logic [CNT_W-1:0] sec_inc;
  logic [31:0]      siu_wide;
  logic [31:0]      siu_lim;
  logic             bypass;
  logic             accept;

  // Effective section count, limited to the sections built
  assign siu_wide = {{(32 - SECT_CNT_W){1'b0}}, sections_in_use};
  assign siu_lim  = (siu_wide > 32'(NUM_SECTIONS)) ? 32'(NUM_SECTIONS) : siu_wide;
  assign num_sec  = siu_lim[CNT_W-1:0];
  assign bypass   = !filter_on || (sections_in_use == '0);

  assign in_stall = rst || (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign sec_inc  = sec + CNT_W'(1);
  assign sec_addr = sec[SEC_W-1:0];

  // Next state and commands
  always_comb begin
    state_next = state;
    tap_next   = tap;
    sec_next   = sec;
    cmd        = '0;
    cmd.tap    = tap;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          sec_next   = '0;
          state_next = bypass ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        tap_next   = TAP_B0;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        if (tap == TAP_A2) begin
          state_next = ST_FLUSH;
        end else begin
          tap_next = tap + 3'd1;
        end
      end
      ST_FLUSH: begin
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round  = 1'b1;
        sec_next   = sec_inc;
        state_next = (sec_inc == num_sec) ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tap   <= TAP_B0;
      sec   <= '0;
    end else begin
      state <= state_next;
      tap   <= tap_next;
      sec   <= sec_next;
    end
  end

endmodule

@@ rtl/cbq_datapath.sv @@
// Datapath: section history memory, shared multiplier, accumulator, rounding.
`timescale 1ns / 1ps

module cbq_datapath import cbq_pkg::*; #(
  parameter int NUM_SECTIONS   = DEF_NUM_SECTIONS,
  parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  parameter int SEC_W          = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  input  logic [SEC_W-1:0]              sec_addr,
  input  coef_t                         coef,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output status_t                       status,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);

  localparam int SB     = SAMPLE_BITS;
  localparam int ROW_W  = 4 * SB;
  localparam int PROD_W = COEF_W + SB;
  localparam int ACC_W  = PROD_W + 3;

  localparam logic signed [ACC_W-1:0] RND =
    {{(ACC_W - 1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SMAX = {{(ACC_W - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMIN = {{(ACC_W - SB + 1){1'b1}}, {(SB - 1){1'b0}}};

  // History row: {y2, y1, x2, x1}
  logic [ROW_W-1:0]        mem [NUM_SECTIONS];
  logic [NUM_SECTIONS-1:0] row_ok;
  logic [ROW_W-1:0]        rd_row;
  logic                    rd_ok;

  logic signed [SB-1:0]     cur;
  logic signed [SB-1:0]     x1, x2, y1, y2;
  logic signed [SB-1:0]     op_sel;
  logic signed [COEF_W-1:0] coef_sel;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;
  logic                     prod_neg;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rnd_sum;
  logic signed [ACC_W-1:0]  shifted;
  logic signed [SB-1:0]     res;

  // Unwritten sections read as zero history
  assign x1 = rd_ok ? rd_row[SB-1:0]        : '0;
  assign x2 = rd_ok ? rd_row[2*SB-1:SB]     : '0;
  assign y1 = rd_ok ? rd_row[3*SB-1:2*SB]   : '0;
  assign y2 = rd_ok ? rd_row[4*SB-1:3*SB]   : '0;

  // Operand and coefficient select per tap
  always_comb begin
    case (cmd.tap)
      TAP_B0:  begin op_sel = cur; coef_sel = coef.b0; end
      TAP_B1:  begin op_sel = x1;  coef_sel = coef.b1; end
      TAP_B2:  begin op_sel = x2;  coef_sel = coef.b2; end
      TAP_A1:  begin op_sel = y1;  coef_sel = coef.a1; end
      TAP_A2:  begin op_sel = y2;  coef_sel = coef.a2; end
      default: begin op_sel = '0;  coef_sel = '0;      end
    endcase
  end

  // Rounding to nearest, floor shift, saturation
  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
  assign rnd_sum  = acc + RND;
  assign shifted  = rnd_sum >>> COEF_FRAC_BITS;
  always_comb begin
    if (shifted > SMAX) begin
      res = SMAX[SB-1:0];
    end else if (shifted < SMIN) begin
      res = SMIN[SB-1:0];
    end else begin
      res = shifted[SB-1:0];
    end
  end

  // History memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_row <= mem[sec_addr];
    end
    if (cmd.round) begin
      mem[sec_addr] <= {y1, res, x1, cur};
    end
  end

  // Row valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
      rd_ok  <= 1'b0;
    end else begin
      if (cmd.rd) begin
        rd_ok <= row_ok[sec_addr];
      end
      if (cmd.round) begin
        row_ok[sec_addr] <= 1'b1;
      end
    end
  end

  // Shared multiplier with registered product
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.mul;
    end
    if (cmd.mul) begin
      prod     <= coef_sel * op_sel;
      prod_neg <= (cmd.tap == TAP_A1) || (cmd.tap == TAP_A2);
    end
  end

  // Accumulator and running sample
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= prod_neg ? (acc - prod_ext) : (acc + prod_ext);
    end
    if (cmd.load) begin
      cur <= sample_in;
    end else if (cmd.round) begin
      cur <= res;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      sample_out <= cur;
    end
  end

  assign status.out_busy = out_valid && out_stall;

endmodule

@@ rtl/cascaded_biquad_iir_filter.sv @@
// Top level of the cascaded biquad filter: register file and sequencer/datapath.
`timescale 1ns / 1ps

// Cascaded direct-form-I biquad filter with shared coefficients.
// Input channel: in_valid / in_stall carry one signed sample_in per request.
// Output channel: out_valid / out_stall carry one signed sample_out per request.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock edge
// (0..4 b0 b1 b2 a1 a2, 5 filter_on, 6 sections_in_use); write only while idle.
// One multiplier is shared by all taps of all sections. Each section steps
// through a history read, five multiplies, accumulate, round and write back.
// With filtering off or no sections in use, an accepted item skips the sections
// and goes straight to the output register. The next request is accepted once
// the controller is back to idle, so a new item is not taken before the last
// one has been moved into the output register.
// The output register holds the finished result; a new sample is taken and
// filtered while it waits, and the block holds the new result until the
// receiver drops out_stall.
// Reset clears all section history, loads b0 = 1.0, other coefficients 0,
// filtering on, one section, and empties the output register.

module cascaded_biquad_iir_filter import cbq_pkg::*; #(
  parameter int NUM_SECTIONS   = DEF_NUM_SECTIONS,
  parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);

  localparam int SEC_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
  localparam int CNT_W = $clog2(NUM_SECTIONS + 1);

  coef_t                 coef;
  logic                  filter_on;
  logic [SECT_CNT_W-1:0] sections_in_use;
  cmd_t                  cmd;
  status_t               status;
  logic [SEC_W-1:0]      sec_addr;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.b0         <= B0_RESET;
      coef.b1         <= '0;
      coef.b2         <= '0;
      coef.a1         <= '0;
      coef.a2         <= '0;
      filter_on       <= 1'b1;
      sections_in_use <= SECT_CNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_B0:       coef.b0 <= cfg_data;
        REG_B1:       coef.b1 <= cfg_data;
        REG_B2:       coef.b2 <= cfg_data;
        REG_A1:       coef.a1 <= cfg_data;
        REG_A2:       coef.a2 <= cfg_data;
        REG_FILTER:   filter_on <= cfg_data[0];
        REG_SECTIONS: sections_in_use <= cfg_data[SECT_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cbq_ctrl #(
    .NUM_SECTIONS (NUM_SECTIONS),
    .SEC_W        (SEC_W),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .filter_on       (filter_on),
    .sections_in_use (sections_in_use),
    .status          (status),
    .cmd             (cmd),
    .sec_addr        (sec_addr)
  );

  cbq_datapath #(
    .NUM_SECTIONS   (NUM_SECTIONS),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .SEC_W          (SEC_W)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sec_addr   (sec_addr),
    .coef       (coef),
    .sample_in  (sample_in),
    .status     (status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out)
  );

endmodule
